// File: design/tms_pkg.sv
`default_nettype none

package tms_pkg;

	localparam int FRAME_LEN_BITS_DEF = 16;
	localparam logic [15:0] MSS_LIMIT_RST = 16'd1460;

	localparam logic [4:0] ETH_HDR_BYTES = 5'd14;
	localparam logic [7:0] ETH_P_IP_HI = 8'h08;
	localparam logic [7:0] ETH_P_IP_LO = 8'h00;
	localparam logic [7:0] IP_PROTO_TCP = 8'd6;
	localparam logic [3:0] IP_VERSION_4 = 4'd4;
	localparam logic [3:0] MIN_HDR_WORDS = 4'd5;
	localparam int TH_SYN_BIT = 1;
	localparam logic [5:0] TCP_BASE_LEN = 6'd20;
	localparam logic [7:0] OPT_KIND_END = 8'd0;
	localparam logic [7:0] OPT_KIND_NOOP = 8'd1;
	localparam logic [7:0] OPT_KIND_MSS = 8'd2;
	localparam logic [7:0] OPT_MSS_BYTES = 8'd4;
	localparam logic [7:0] TCP_OPT_MIN_LEN = 8'd2;

	// byte positions inside the frame, counted from zero
	localparam int POS_ETYPE_HI = 12;
	localparam int POS_ETYPE_LO = 13;
	localparam int POS_IP_VER = 14;
	localparam int POS_IP_PROTO = 23;
	// offsets inside the TCP header
	localparam logic [5:0] TCP_REL_OFF = 6'd12;
	localparam logic [5:0] TCP_REL_FLAGS = 6'd13;

	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_AW = $clog2(OUTQ_DEPTH);

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_KIND   = 3'd1,
		PH_LEN    = 3'd2,
		PH_MSS_HI = 3'd3,
		PH_MSS_LO = 3'd4,
		PH_DONE   = 3'd5
	} opt_phase_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
		logic       mss_rewritten;
	} tms_res_t;

	typedef struct packed {
		tms_res_t   first;
		tms_res_t   second;
		logic [1:0] cnt;
	} tms_push_t;

endpackage

`default_nettype wire

// File: design/tms_if.sv
`default_nettype none

interface tms_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        frame_start;
	logic        frame_end;
	logic [15:0] frame_length;

	modport source (output valid, data_byte, frame_start, frame_end, frame_length,
		input ready);
	modport sink (input valid, data_byte, frame_start, frame_end, frame_length,
		output ready);
endinterface

interface tms_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;
	logic       mss_rewritten;

	modport source (output valid, out_byte, out_last, mss_rewritten, input ready);
	modport sink (input valid, out_byte, out_last, mss_rewritten, output ready);
endinterface

`default_nettype wire

// File: design/tcp_syn_mss_clamper.sv
// Latency: a byte is queued for output one accepted byte later (on frame_end at once);
// it can leave the cycle after the accepting edge.
// Throughput: one byte per cycle; ready drops only while the four-entry output queue
// lacks room for the two requests a single byte can produce.
// Reset: arst_n clears all parser state, empties the queue and loads mss_limit with 1460.
`default_nettype none

module tcp_syn_mss_clamper
	import tms_pkg::*;
#(
	parameter int FRAME_LEN_BITS = FRAME_LEN_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	tms_in_if.sink           ingress,
	tms_out_if.source        egress,
	input  wire logic        mss_limit_we,
	input  wire logic [15:0] mss_limit_wdata
);

	tms_push_t push;
	tms_res_t  res;
	logic      space_ok, accept;

	assign ingress.ready = space_ok;
	assign accept = ingress.valid && space_ok;

	tms_parser #(
		.FRAME_LEN_BITS(FRAME_LEN_BITS)
	) u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.data_byte      (ingress.data_byte),
		.frame_start    (ingress.frame_start),
		.frame_end      (ingress.frame_end),
		.frame_length   (ingress.frame_length),
		.mss_limit_we   (mss_limit_we),
		.mss_limit_wdata(mss_limit_wdata),
		.push           (push)
	);

	tms_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_en  (accept),
		.push     (push),
		.space_ok (space_ok),
		.out_valid(egress.valid),
		.out_ready(egress.ready),
		.out_res  (res)
	);

	assign egress.out_byte = res.out_byte;
	assign egress.out_last = res.out_last;
	assign egress.mss_rewritten = res.mss_rewritten;

endmodule

`default_nettype wire

// File: design/tms_parser.sv
`default_nettype none

module tms_parser
	import tms_pkg::*;
#(
	parameter int FRAME_LEN_BITS = FRAME_LEN_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic [7:0]  data_byte,
	input  wire logic        frame_start,
	input  wire logic        frame_end,
	input  wire logic [15:0] frame_length,
	input  wire logic        mss_limit_we,
	input  wire logic [15:0] mss_limit_wdata,
	output tms_push_t        push
);

	localparam int FLB = FRAME_LEN_BITS;
	localparam int LW = FRAME_LEN_BITS + 1;

	logic [FLB-1:0] byte_pos_q, frm_bytes_q;
	logic [5:0]     ip_hdr_q, tcp_hdr_q, nxt_q;
	logic           elig_q, held_vld_q, clamp_q;
	opt_phase_t     phase_q;
	logic [7:0]     kind_q, mss_hi_q, held_byte_q;
	logic [15:0]    mss_limit_q;

	logic [FLB-1:0] pos, flen, diff;
	logic [5:0]     ip, tcp, nxt, rel;
	logic           elig, held_v, clamp;
	opt_phase_t     phase;
	logic [7:0]     kind, mss_hi, hb, b;
	logic [6:0]     tstart, nxt1, nxt2, nxt3, rel7, thl7;
	logic [8:0]     sum9;
	logic [3:0]     ihl, off;
	tms_res_t       cur;

	always_comb begin
		b = data_byte;
		pos = byte_pos_q;
		flen = frm_bytes_q;
		ip = ip_hdr_q;
		tcp = tcp_hdr_q;
		nxt = nxt_q;
		elig = elig_q;
		held_v = held_vld_q;
		clamp = clamp_q;
		phase = phase_q;
		kind = kind_q;
		mss_hi = mss_hi_q;
		hb = held_byte_q;
		push = '0;
		ihl = b[3:0];
		off = b[7:4];
		tstart = '0;
		diff = '0;
		rel = '0;
		sum9 = '0;
		nxt1 = '0;
		nxt2 = '0;
		nxt3 = '0;
		thl7 = '0;

		if (frame_start) begin
			// close out the previous frame with the byte still held
			if (held_vld_q) begin
				push.first = '{out_byte: held_byte_q, out_last: 1'b1, mss_rewritten: clamp_q};
				push.cnt = 2'd1;
			end
			held_v = 1'b0;
			pos = '0;
			flen = frame_length[FLB-1:0];
			ip = '0;
			tcp = '0;
			phase = PH_IDLE;
			nxt = TCP_BASE_LEN;
			kind = '0;
			mss_hi = '0;
			clamp = 1'b0;
			elig = flen >= FLB'(ETH_HDR_BYTES);
		end else if (byte_pos_q != '1) begin
			pos = byte_pos_q + 1'b1;
		end

		if (elig) begin
			if (pos == FLB'(POS_ETYPE_HI) && b != ETH_P_IP_HI) elig = 1'b0;
			if (pos == FLB'(POS_ETYPE_LO) && b != ETH_P_IP_LO) elig = 1'b0;
			if (pos == FLB'(POS_IP_VER)) begin
				ip = {ihl, 2'b00};
				if (b[7:4] != IP_VERSION_4 || ihl < MIN_HDR_WORDS ||
						LW'(ETH_HDR_BYTES) + LW'({ihl, 2'b00}) > LW'(flen))
					elig = 1'b0;
			end
			if (pos == FLB'(POS_IP_PROTO) && b != IP_PROTO_TCP) elig = 1'b0;
		end

		tstart = 7'(ETH_HDR_BYTES) + {1'b0, ip};
		diff = pos - FLB'(tstart);
		rel = diff[5:0];
		rel7 = {1'b0, rel};
		if (elig && pos > FLB'(POS_IP_VER) && pos >= FLB'(tstart) && diff[FLB-1:6] == '0) begin
			if (rel == TCP_REL_OFF) begin
				tcp = {off, 2'b00};
				if (off < MIN_HDR_WORDS || LW'(tstart) + LW'({off, 2'b00}) > LW'(flen))
					elig = 1'b0;
			end else if (rel == TCP_REL_FLAGS) begin
				if (!b[TH_SYN_BIT]) elig = 1'b0;
			end
			if (elig && rel == TCP_BASE_LEN && phase == PH_IDLE) begin
				nxt = TCP_BASE_LEN;
				phase = (tcp > TCP_BASE_LEN) ? PH_KIND : PH_DONE;
			end
			if (elig) begin
				nxt1 = {1'b0, nxt} + 7'd1;
				nxt2 = {1'b0, nxt} + 7'd2;
				nxt3 = {1'b0, nxt} + 7'd3;
				thl7 = {1'b0, tcp};
				sum9 = {3'b000, nxt} + {1'b0, b};
				if (phase == PH_KIND && rel == nxt) begin
					if (b == OPT_KIND_END) begin
						phase = PH_DONE;
					end else if (b == OPT_KIND_NOOP) begin
						nxt = nxt1[5:0];
						if (nxt1 >= thl7) phase = PH_DONE;
					end else if (nxt1 >= thl7) begin
						phase = PH_DONE;
					end else begin
						kind = b;
						phase = PH_LEN;
					end
				end else if (phase == PH_LEN && rel7 == nxt1) begin
					if (b < TCP_OPT_MIN_LEN || sum9 > {3'b000, tcp}) begin
						phase = PH_DONE;
					end else if (kind == OPT_KIND_MSS && b == OPT_MSS_BYTES) begin
						phase = PH_MSS_HI;
					end else begin
						nxt = sum9[5:0];
						phase = (sum9 >= {3'b000, tcp}) ? PH_DONE : PH_KIND;
					end
				end else if (phase == PH_MSS_HI && rel7 == nxt2) begin
					mss_hi = b;
					phase = PH_MSS_LO;
				end else if (phase == PH_MSS_LO && rel7 == nxt3) begin
					phase = PH_DONE;
					// rewrite the held high byte and the current low byte
					if ({mss_hi, b} > mss_limit_q && held_v) begin
						hb = mss_limit_q[15:8];
						b = mss_limit_q[7:0];
						clamp = 1'b1;
					end
				end
			end
		end

		if (held_v) begin
			push.first = '{out_byte: hb, out_last: 1'b0, mss_rewritten: 1'b0};
			push.cnt = 2'd1;
		end

		cur = '{out_byte: b, out_last: 1'b1, mss_rewritten: clamp};
		if (frame_end) begin
			if (push.cnt == 2'd0) begin
				push.first = cur;
			end else begin
				push.second = cur;
			end
			push.cnt = push.cnt + 2'd1;
			held_v = 1'b0;
			elig = 1'b0;
			phase = PH_IDLE;
			clamp = 1'b0;
		end else begin
			hb = b;
			held_v = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q <= '0;
			frm_bytes_q <= '0;
			ip_hdr_q <= '0;
			tcp_hdr_q <= '0;
			nxt_q <= TCP_BASE_LEN;
			elig_q <= 1'b0;
			held_vld_q <= 1'b0;
			clamp_q <= 1'b0;
			phase_q <= PH_IDLE;
			kind_q <= '0;
			mss_hi_q <= '0;
			held_byte_q <= '0;
		end else if (accept) begin
			byte_pos_q <= pos;
			frm_bytes_q <= flen;
			ip_hdr_q <= ip;
			tcp_hdr_q <= tcp;
			nxt_q <= nxt;
			elig_q <= elig;
			held_vld_q <= held_v;
			clamp_q <= clamp;
			phase_q <= phase;
			kind_q <= kind;
			mss_hi_q <= mss_hi;
			held_byte_q <= hb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mss_limit_q <= MSS_LIMIT_RST;
		end else if (mss_limit_we) begin
			mss_limit_q <= mss_limit_wdata;
		end
	end

endmodule

`default_nettype wire

// File: design/tms_outq.sv
`default_nettype none

module tms_outq
	import tms_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push_en,
	input  wire tms_push_t push,
	output logic           space_ok,
	output logic           out_valid,
	input  wire logic      out_ready,
	output tms_res_t       out_res
);

	tms_res_t                mem_q [OUTQ_DEPTH];
	logic [OUTQ_AW-1:0]      wp_q, rp_q;
	logic [OUTQ_AW:0]        cnt_q;
	logic [1:0]              n_push;
	logic                    pop;

	assign n_push = push_en ? push.cnt : 2'd0;
	assign out_valid = cnt_q != '0;
	assign pop = out_valid && out_ready;
	assign out_res = mem_q[rp_q];
	// room for the two requests one item can produce
	assign space_ok = cnt_q <= (OUTQ_AW+1)'(OUTQ_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) mem_q[wp_q] <= push.first;
		if (n_push == 2'd2) mem_q[wp_q + 1'b1] <= push.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + OUTQ_AW'(n_push);
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (OUTQ_AW+1)'(n_push) - (OUTQ_AW+1)'(pop);
		end
	end

endmodule

`default_nettype wire

// File: test/tb_tcp_syn_mss_clamper.sv
`default_nettype none

module tb_tcp_syn_mss_clamper;
	import tms_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 400;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        mss_limit_we;
	logic [15:0] mss_limit_wdata;

	tms_in_if  in_ch ();
	tms_out_if out_ch ();

	tcp_syn_mss_clamper dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.ingress         (in_ch),
		.egress          (out_ch),
		.mss_limit_we    (mss_limit_we),
		.mss_limit_wdata (mss_limit_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// clamper state as the predictor sees it
	bit [15:0]  mss_lim;
	bit [15:0]  pos_cnt;
	bit [15:0]  frm_bytes;
	bit [5:0]   ip_hlen;
	bit [5:0]   tcp_hlen;
	bit         elig;
	opt_phase_t phase;
	bit [5:0]   nxt_opt;
	bit [7:0]   opt_kind;
	bit [7:0]   mss_hi;
	bit [7:0]   held_byte;
	bit         held_vld;
	bit         clamped;

	tms_res_t exp_q[$];
	tms_res_t seen_res;
	tms_res_t want_res;

	bit [7:0] pkt[$];
	bit [7:0] tcp_opts[$];

	int err_cnt = 0;
	int res_cnt = 0;
	int req_cnt = 0;
	int cyc = 0;
	int gap_max = 3;
	int burst_left = 0;
	int hold_left = 0;
	int pat_left = 0;
	bit hold_req = 1'b0;
	bit [31:0] rdy_pat;

	function automatic void queue_result(bit [7:0] b, bit last, bit rew);
		tms_res_t r;
		r.out_byte = b;
		r.out_last = last;
		r.mss_rewritten = rew;
		exp_q.push_back(r);
	endfunction

	function automatic void clear_parse();
		pos_cnt = '0;
		frm_bytes = '0;
		ip_hlen = '0;
		tcp_hlen = '0;
		elig = 1'b0;
		phase = PH_IDLE;
		nxt_opt = TCP_BASE_LEN;
		opt_kind = '0;
		mss_hi = '0;
		clamped = 1'b0;
	endfunction

	function automatic bit [7:0] opt_walk(int unsigned rel, bit [7:0] b_in);
		int unsigned thl;
		int unsigned nxt;
		bit [7:0] b;
		bit [15:0] v;
		thl = tcp_hlen;
		nxt = nxt_opt;
		b = b_in;
		if (phase == PH_KIND && rel == nxt) begin
			if (b == OPT_KIND_END) begin
				phase = PH_DONE;
			end else if (b == OPT_KIND_NOOP) begin
				nxt_opt = 6'(nxt + 1);
				if (nxt + 1 >= thl)
					phase = PH_DONE;
			end else if (nxt + 1 >= thl) begin
				phase = PH_DONE;
			end else begin
				opt_kind = b;
				phase = PH_LEN;
			end
		end else if (phase == PH_LEN && rel == nxt + 1) begin
			if (b < TCP_OPT_MIN_LEN || nxt + b > thl) begin
				phase = PH_DONE;
			end else if (opt_kind == OPT_KIND_MSS && b == OPT_MSS_BYTES) begin
				phase = PH_MSS_HI;
			end else begin
				nxt_opt = 6'(nxt + b);
				phase = (nxt + b >= thl) ? PH_DONE : PH_KIND;
			end
		end else if (phase == PH_MSS_HI && rel == nxt + 2) begin
			mss_hi = b;
			phase = PH_MSS_LO;
		end else if (phase == PH_MSS_LO && rel == nxt + 3) begin
			v = {mss_hi, b};
			phase = PH_DONE;
			// rewrite both halves: the high byte is still held back
			if (v > mss_lim && held_vld) begin
				held_byte = mss_lim[15:8];
				b = mss_lim[7:0];
				clamped = 1'b1;
			end
		end
		return b;
	endfunction

	function automatic void clamp_predict(bit [7:0] d, bit fs, bit fe, bit [15:0] flen);
		bit [7:0] b;
		int unsigned pos;
		int unsigned tstart;
		int unsigned rel;
		int unsigned ihl;
		int unsigned off;
		b = d;
		if (fs) begin
			if (held_vld) begin
				queue_result(held_byte, 1'b1, clamped);
				held_vld = 1'b0;
			end
			clear_parse();
			frm_bytes = flen;
			elig = flen >= ETH_HDR_BYTES;
		end else if (pos_cnt != 16'hFFFF) begin
			pos_cnt++;
		end
		pos = pos_cnt;

		if (elig) begin
			if (pos == POS_ETYPE_HI && b != ETH_P_IP_HI)
				elig = 1'b0;
			if (pos == POS_ETYPE_LO && b != ETH_P_IP_LO)
				elig = 1'b0;
			if (pos == POS_IP_VER) begin
				ihl = b[3:0];
				ip_hlen = 6'(ihl * 4);
				if (b[7:4] != IP_VERSION_4 || ihl < MIN_HDR_WORDS ||
						int'(ETH_HDR_BYTES) + ihl * 4 > frm_bytes)
					elig = 1'b0;
			end
			if (pos == POS_IP_PROTO && b != IP_PROTO_TCP)
				elig = 1'b0;
		end
		if (elig && pos > POS_IP_VER) begin
			tstart = int'(ETH_HDR_BYTES) + ip_hlen;
			if (pos >= tstart && pos - tstart < 64) begin
				rel = pos - tstart;
				if (rel == TCP_REL_OFF) begin
					off = b[7:4];
					tcp_hlen = 6'(off * 4);
					if (off < MIN_HDR_WORDS || tstart + off * 4 > frm_bytes)
						elig = 1'b0;
				end else if (rel == TCP_REL_FLAGS) begin
					if (!b[TH_SYN_BIT])
						elig = 1'b0;
				end
				if (elig && rel == TCP_BASE_LEN && phase == PH_IDLE) begin
					nxt_opt = TCP_BASE_LEN;
					phase = (tcp_hlen > TCP_BASE_LEN) ? PH_KIND : PH_DONE;
				end
				if (elig)
					b = opt_walk(rel, b);
			end
		end

		if (held_vld)
			queue_result(held_byte, 1'b0, 1'b0);
		if (fe) begin
			queue_result(b, 1'b1, clamped);
			held_vld = 1'b0;
			elig = 1'b0;
			phase = PH_IDLE;
			clamped = 1'b0;
		end else begin
			held_byte = b;
			held_vld = 1'b1;
		end
	endfunction

	function automatic void log_err(string msg);
		err_cnt++;
		if (err_cnt <= 10)
			$display("%0t: %s", $time, msg);
	endfunction

	// ---------------------------------------------------------------- frames

	function automatic void opt_raw(bit [7:0] b);
		tcp_opts.push_back(b);
	endfunction

	function automatic void opt_mss(bit [15:0] v);
		tcp_opts.push_back(OPT_KIND_MSS);
		tcp_opts.push_back(OPT_MSS_BYTES);
		tcp_opts.push_back(v[15:8]);
		tcp_opts.push_back(v[7:0]);
	endfunction

	function automatic void opt_gen(bit [7:0] kind, bit [7:0] len);
		tcp_opts.push_back(kind);
		tcp_opts.push_back(len);
		for (int i = 2; i < len; i++)
			tcp_opts.push_back(8'($urandom));
	endfunction

	// Ethernet + IPv4 + TCP SYN, options from tcp_opts padded with EOL
	function automatic void build_syn(int ihl, int doff, int pay);
		int n;
		pkt.delete();
		repeat (12) pkt.push_back(8'($urandom));
		pkt.push_back(ETH_P_IP_HI);
		pkt.push_back(ETH_P_IP_LO);
		pkt.push_back({IP_VERSION_4, 4'(ihl)});
		repeat (8) pkt.push_back(8'($urandom));
		pkt.push_back(IP_PROTO_TCP);
		repeat (ihl * 4 - 10) pkt.push_back(8'($urandom));
		repeat (12) pkt.push_back(8'($urandom));
		pkt.push_back({4'(doff), 4'($urandom)});
		pkt.push_back(8'($urandom) | 8'(1 << TH_SYN_BIT));
		repeat (6) pkt.push_back(8'($urandom));
		n = doff * 4 - 20;
		for (int i = 0; i < n; i++)
			pkt.push_back(i < tcp_opts.size() ? tcp_opts[i] : OPT_KIND_END);
		repeat (pay) pkt.push_back(8'($urandom));
	endfunction

	function automatic void syn_mss(int ihl, int doff, bit [15:0] v);
		tcp_opts.delete();
		opt_mss(v);
		build_syn(ihl, doff, 8);
	endfunction

	function automatic bit [15:0] rand_mss();
		case ($urandom_range(0, 3))
			0: return 16'(mss_lim + $urandom_range(0, 2) - 1);
			1: return 16'($urandom);
			2: return 16'hFFFF;
			default: return 16'($urandom_range(0, 1500));
		endcase
	endfunction

	// ---------------------------------------------------------------- driving

	task automatic send_req(input bit [7:0] d, input bit fs, input bit fe,
			input bit [15:0] flen);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			repeat (gap) begin
				@(negedge clk);
				in_ch.valid = 1'b0;
			end
		end
		@(negedge clk);
		in_ch.valid = 1'b1;
		in_ch.data_byte = d;
		in_ch.frame_start = fs;
		in_ch.frame_end = fe;
		in_ch.frame_length = flen;
		do @(posedge clk); while (!in_ch.ready);
		clamp_predict(d, fs, fe, flen);
		req_cnt++;
		burst_left--;
	endtask

	task automatic send_frame(input bit [15:0] flen, input int n, input bit with_end);
		for (int i = 0; i < n; i++)
			send_req(pkt[i], i == 0, with_end && i == n - 1,
				i == 0 ? flen : 16'($urandom));
	endtask

	task automatic send_pkt;
		send_frame(16'(pkt.size()), pkt.size(), 1'b1);
	endtask

	task automatic drain_results;
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (exp_q.size() != 0)
			@(posedge clk);
		// let a byte still held inside the block settle
		repeat (10) @(posedge clk);
	endtask

	task automatic set_mss_limit(input bit [15:0] v);
		drain_results();
		@(negedge clk);
		mss_limit_we = 1'b1;
		mss_limit_wdata = v;
		@(negedge clk);
		mss_limit_we = 1'b0;
		mss_lim = v;
	endtask

	// ---------------------------------------------------------------- result side

	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			out_ch.ready = 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
			out_ch.ready = 1'b0;
		end else begin
			if (pat_left == 0) begin
				pat_left = $urandom_range(8, 64);
				case ($urandom_range(0, 3))
					0: rdy_pat = '1;
					1: rdy_pat = $urandom;
					2: rdy_pat = $urandom | $urandom;
					default: rdy_pat = $urandom & $urandom;
				endcase
			end
			out_ch.ready = rdy_pat[0];
			rdy_pat = {rdy_pat[0], rdy_pat[31:1]};
			pat_left--;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			seen_res.out_byte = out_ch.out_byte;
			seen_res.out_last = out_ch.out_last;
			seen_res.mss_rewritten = out_ch.mss_rewritten;
			if (exp_q.size() == 0) begin
				log_err($sformatf("unexpected result: byte %02h last %0b rewritten %0b",
					seen_res.out_byte, seen_res.out_last, seen_res.mss_rewritten));
			end else begin
				want_res = exp_q.pop_front();
				if (seen_res.out_byte !== want_res.out_byte ||
						seen_res.out_last !== want_res.out_last ||
						seen_res.mss_rewritten !== want_res.mss_rewritten)
					log_err($sformatf(
						"result %0d: expected byte %02h last %0b rewritten %0b, got %02h %0b %0b",
						res_cnt, want_res.out_byte, want_res.out_last, want_res.mss_rewritten,
						seen_res.out_byte, seen_res.out_last, seen_res.mss_rewritten));
			end
			res_cnt++;
		end
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------- tests

	task automatic test_clamp_basic;
		syn_mss(5, 6, 16'd1500);
		send_pkt();
		syn_mss(5, 6, 16'd1460);
		send_pkt();
		syn_mss(5, 6, 16'd1461);
		send_pkt();
		// IP options and the longest TCP header
		tcp_opts.delete();
		repeat (3) opt_raw(OPT_KIND_NOOP);
		opt_mss(16'hFFFF);
		build_syn(15, 15, 4);
		send_pkt();
	endtask

	task automatic test_option_walk;
		tcp_opts.delete();
		opt_raw(OPT_KIND_END);
		opt_mss(16'd9000);
		build_syn(5, 7, 4);
		send_pkt();
		// skip a long option ahead of MSS
		tcp_opts.delete();
		opt_gen(8'd8, 8'd10);
		opt_mss(16'd9000);
		build_syn(5, 9, 4);
		send_pkt();
		// length below two stops the walk
		tcp_opts.delete();
		opt_raw(8'd3);
		opt_raw(8'd1);
		opt_mss(16'd9000);
		build_syn(5, 7, 4);
		send_pkt();
		// length running past the header
		tcp_opts.delete();
		opt_raw(8'd3);
		opt_raw(8'd40);
		opt_mss(16'd9000);
		build_syn(5, 7, 4);
		send_pkt();
		// MSS kind with the wrong length is skipped like any option
		tcp_opts.delete();
		opt_gen(OPT_KIND_MSS, 8'd3);
		opt_mss(16'd9000);
		build_syn(5, 8, 4);
		send_pkt();
		// only the first MSS counts
		tcp_opts.delete();
		opt_mss(16'd1000);
		opt_mss(16'd9000);
		build_syn(5, 7, 4);
		send_pkt();
		// option kind on the last header byte
		tcp_opts.delete();
		repeat (3) opt_raw(OPT_KIND_NOOP);
		opt_raw(8'd5);
		build_syn(5, 6, 4);
		send_pkt();
		// minimal two-byte option, then MSS
		tcp_opts.delete();
		opt_gen(8'd5, 8'd2);
		opt_mss(16'd9000);
		build_syn(5, 7, 4);
		send_pkt();
		// no options at all, MSS-like bytes in the payload
		tcp_opts.delete();
		build_syn(5, 5, 0);
		pkt.push_back(OPT_KIND_MSS);
		pkt.push_back(OPT_MSS_BYTES);
		pkt.push_back(8'hFF);
		pkt.push_back(8'hFF);
		send_pkt();
	endtask

	task automatic test_header_rejects;
		syn_mss(5, 6, 16'd9000);
		pkt[POS_ETYPE_HI] = 8'h86;
		send_pkt();
		syn_mss(5, 6, 16'd9000);
		pkt[POS_ETYPE_LO] = 8'hDD;
		send_pkt();
		syn_mss(5, 6, 16'd9000);
		pkt[POS_IP_VER] = 8'h65;
		send_pkt();
		syn_mss(5, 6, 16'd9000);
		pkt[POS_IP_VER] = 8'h44;
		send_pkt();
		syn_mss(5, 6, 16'd9000);
		pkt[POS_IP_PROTO] = 8'd17;
		send_pkt();
		syn_mss(5, 6, 16'd9000);
		pkt[46] = 8'h4F;
		send_pkt();
		syn_mss(5, 6, 16'd9000);
		pkt[47] = pkt[47] & ~8'(1 << TH_SYN_BIT);
		send_pkt();
		// IP header not inside the length, then lengths below the Ethernet header
		syn_mss(5, 6, 16'd9000);
		send_frame(16'd33, pkt.size(), 1'b1);
		syn_mss(5, 6, 16'd9000);
		send_frame(16'd13, pkt.size(), 1'b1);
		syn_mss(5, 6, 16'd9000);
		send_frame(16'd0, pkt.size(), 1'b1);
	endtask

	task automatic test_framing;
		// bytes outside any frame, the last one flagged as an end
		repeat (3) send_req(8'($urandom), 1'b0, 1'b0, 16'($urandom));
		send_req(8'($urandom), 1'b0, 1'b1, 16'($urandom));
		// clamped frame left open, closed by the next start
		syn_mss(5, 6, 16'd9000);
		send_frame(16'(pkt.size()), pkt.size(), 1'b0);
		syn_mss(5, 6, 16'd9000);
		send_frame(16'(pkt.size()), 57, 1'b1);
		syn_mss(5, 6, 16'd9000);
		send_frame(16'(pkt.size()), 58, 1'b1);
		// length covers exactly the headers, payload runs past it
		syn_mss(5, 6, 16'd9000);
		send_frame(16'd58, pkt.size(), 1'b1);
		syn_mss(5, 6, 16'd9000);
		send_frame(16'd57, pkt.size(), 1'b1);
		send_req(8'($urandom), 1'b1, 1'b1, 16'($urandom));
		syn_mss(5, 6, 16'd9000);
		send_frame(16'hFFFF, pkt.size(), 1'b1);
	endtask

	task automatic test_limit_extremes;
		set_mss_limit(16'd0);
		syn_mss(5, 6, 16'd1);
		send_pkt();
		syn_mss(5, 6, 16'd0);
		send_pkt();
		set_mss_limit(16'hFFFF);
		syn_mss(5, 6, 16'hFFFF);
		send_pkt();
		syn_mss(5, 6, 16'hFFFE);
		send_pkt();
		set_mss_limit(16'($urandom));
		syn_mss(5, 6, 16'($urandom));
		send_pkt();
		syn_mss(5, 6, 16'(mss_lim + 1));
		send_pkt();
		set_mss_limit(MSS_LIMIT_RST);
	endtask

	task automatic test_backpressure;
		gap_max = 0;
		hold_req = 1'b1;
		syn_mss(5, 6, 16'd9000);
		send_pkt();
		syn_mss(5, 6, 16'd9000);
		send_pkt();
		gap_max = 3;
	endtask

	task automatic rand_frame;
		int ihl;
		int doff;
		int pick;
		int n;
		bit [15:0] flen;
		tcp_opts.delete();
		ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
		doff = $urandom_range(5, 15);
		while (tcp_opts.size() < doff * 4 - 20) begin
			pick = $urandom_range(0, 99);
			if (pick < 20)
				opt_raw(OPT_KIND_NOOP);
			else if (pick < 55)
				opt_mss(rand_mss());
			else if (pick < 80)
				opt_gen(8'($urandom_range(3, 255)), 8'($urandom_range(2, 10)));
			else if (pick < 85)
				opt_raw(OPT_KIND_END);
			else
				opt_raw(8'($urandom));
		end
		build_syn(ihl, doff, $urandom_range(0, 24));

		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			pkt.delete();
			repeat ($urandom_range(1, 80)) pkt.push_back(8'($urandom));
		end else if (pick < 20) begin
			pkt[$urandom_range(POS_ETYPE_HI, 14 + ihl * 4 + 13)] = 8'($urandom);
		end

		case ($urandom_range(0, 7))
			0: flen = 16'($urandom_range(0, pkt.size() + 8));
			1: flen = 16'($urandom);
			default: flen = 16'(pkt.size());
		endcase

		if ($urandom_range(0, 19) == 0)
			repeat ($urandom_range(1, 4))
				send_req(8'($urandom), 1'b0, $urandom_range(0, 4) == 0, 16'($urandom));

		n = pkt.size();
		pick = $urandom_range(0, 19);
		if (pick == 0)
			send_frame(flen, n, 1'b0);
		else if (pick < 3)
			send_frame(flen, $urandom_range(1, n), 1'b1);
		else
			send_frame(flen, n, 1'b1);
	endtask

	task automatic test_random;
		int start_cnt;
		for (int seg = 0; seg < 6; seg++) begin
			case (seg)
				0: set_mss_limit(16'($urandom_range(536, 9000)));
				1: set_mss_limit(16'h0000);
				2: set_mss_limit(16'hFFFF);
				3: set_mss_limit(16'($urandom));
				4: set_mss_limit(MSS_LIMIT_RST);
				default: set_mss_limit(16'($urandom_range(1, 2000)));
			endcase
			gap_max = (seg % 3 == 0) ? 0 : ((seg % 3 == 1) ? 4 : 16);
			start_cnt = req_cnt;
			while (req_cnt - start_cnt < 30)
				rand_frame();
			// close the phase with a complete frame
			syn_mss(5, 6, rand_mss());
			send_pkt();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		mss_limit_we = 1'b0;
		mss_limit_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.frame_start = 1'b0;
		in_ch.frame_end = 1'b0;
		in_ch.frame_length = '0;
		out_ch.ready = 1'b0;

		mss_lim = MSS_LIMIT_RST;
		clear_parse();
		held_byte = '0;
		held_vld = 1'b0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_clamp_basic();
		test_option_walk();
		test_header_rejects();
		test_framing();
		test_limit_extremes();
		test_backpressure();
		test_random();

		drain_results();
		if (err_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
